### rtl/spiking_neuron_array_tick_assert.svh
// assertion macros for the rtl files, included by snat_ctrl
`ifndef SPIKING_NEURON_ARRAY_TICK_ASSERT_SVH
`define SPIKING_NEURON_ARRAY_TICK_ASSERT_SVH

// same-cycle implication
`define SNAT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snat assertion failed");

// next-cycle implication
`define SNAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snat assertion failed");

`endif

### rtl/snat_pkg.sv
`default_nettype none

package snat_pkg;

    localparam int NEURON_COUNT = 8;
    localparam int IDX_W        = 3;
    localparam int CODE_W       = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

    localparam logic [1:0] REG_BASE_THRESHOLD     = 2'd0;
    localparam logic [1:0] REG_NEURON_SIGN        = 2'd1;
    localparam logic [1:0] REG_SENSOR_CONNECTIONS = 2'd2;
    localparam logic [1:0] REG_NEURON_CONNECTIONS = 2'd3;

    localparam logic [CODE_W-1:0] CODE_MAX      = 3'd5;
    localparam logic [9:0]        JITTER_MARGIN = 10'd3;
    localparam logic [7:0]        BYTE_MAX      = 8'hFF;
    localparam logic [7:0]        LEAK_STEP     = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } ctrl_t;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int b = 0; b < 8; b++)
        begin
            n = n + {3'd0, v[b]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/snat_unit.sv
`default_nettype none

module snat_unit
    import snat_pkg::*;
(
    input  wire logic [7:0]        membrane,
    input  wire logic              skip,
    input  wire logic [7:0]        sensors,
    input  wire logic [7:0]        icon,
    input  wire logic [7:0]        ncon,
    input  wire logic [7:0]        previous_spikes,
    input  wire logic [7:0]        neuron_sign,
    input  wire logic [7:0]        base_threshold,
    input  wire logic [CODE_W-1:0] code,
    output logic      [7:0]        membrane_out,
    output logic                   fire
);

    logic [7:0]        act;
    logic [4:0]        add;
    logic [3:0]        sub;
    logic [8:0]        sum;
    logic [7:0]        sat;
    logic [7:0]        integ;
    logic [CODE_W-1:0] code_c;
    logic [9:0]        tsum;
    logic [9:0]        tdiff;
    logic [7:0]        thr;

    always_comb
    begin
        act   = previous_spikes & ncon;
        add   = {1'b0, ones8(sensors & icon)} + {1'b0, ones8(act & neuron_sign)};
        sub   = ones8(act & ~neuron_sign);
        sum   = {1'b0, membrane} + {4'd0, add};
        sat   = sum[8] ? BYTE_MAX : sum[7:0];
        if (skip)
        begin
            integ = membrane;
        end
        else if ({4'd0, sub} > sat)
        begin
            integ = 8'd0;
        end
        else
        begin
            integ = sat - {4'd0, sub};
        end

        // jittered threshold, clamped to a byte
        code_c = (code > CODE_MAX) ? CODE_MAX : code;
        tsum   = {2'd0, base_threshold} + {7'd0, code_c};
        tdiff  = tsum - JITTER_MARGIN;
        if (tsum < JITTER_MARGIN)
        begin
            thr = 8'd0;
        end
        else if (tdiff[8])
        begin
            thr = BYTE_MAX;
        end
        else
        begin
            thr = tdiff[7:0];
        end

        fire = (integ >= thr);
        if (fire)
        begin
            membrane_out = 8'd0;
        end
        else if (integ >= LEAK_STEP)
        begin
            membrane_out = integ - LEAK_STEP;
        end
        else
        begin
            membrane_out = integ;
        end
    end

endmodule

`default_nettype wire

### rtl/snat_ctrl.sv
`default_nettype none

`include "spiking_neuron_array_tick_assert.svh"

module snat_ctrl
    import snat_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic out_free,
    output logic      in_stall,
    output ctrl_t     ctrl
);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall    = 1'b1;
        ctrl.load   = 1'b0;
        ctrl.step   = 1'b0;
        ctrl.finish = 1'b0;
        ctrl.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                ctrl.load = in_valid;
            end
            ST_RUN:
            begin
                ctrl.step   = 1'b1;
                ctrl.finish = (idx_reg == LAST_IDX) && out_free;
            end
            ST_HOLD:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    `SNAT_ASSERT_NEXT(a_load_starts, ctrl.load, state_reg == ST_RUN && idx_reg == '0)
    `SNAT_ASSERT_NEXT(a_step_advances, ctrl.step && idx_reg != LAST_IDX,
        state_reg == ST_RUN && idx_reg == $past(idx_reg) + 1'b1)
    `SNAT_ASSERT_NEXT(a_finish_idles, ctrl.finish, state_reg == ST_IDLE)
    `SNAT_ASSERT_IMPL(a_hold_waits, state_reg == ST_HOLD, !ctrl.step && in_stall)

endmodule

`default_nettype wire

### rtl/spiking_neuron_array_tick.sv
`default_nettype none

// One tick of an eight-neuron leaky integrate-and-fire array. A word is taken on the input
// channel only while the block is idle; one shared neuron unit then updates one membrane per
// cycle, neurons 0 to 7, and a new word is taken only once the tick has finished and the block
// is idle again. The spike byte is held in an output register, so the next word is
// taken while it waits; once the last neuron is updated, the finished tick waits in place
// until that register is free. Registers are written through the configuration channel,
// which is always ready.

module spiking_neuron_array_tick
    import snat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  sensor_spikes,
    input  wire logic [23:0] threshold_jitter,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  spikes,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    ctrl_t       ctrl;
    logic        out_free;

    logic [7:0]  base_threshold_reg;
    logic [7:0]  neuron_sign_reg;
    logic [63:0] sensor_conn_reg;
    logic [63:0] neuron_conn_reg;

    logic [7:0]  sensors_reg;
    logic [23:0] jitter_reg;
    logic [7:0]  prev_spikes_reg;
    logic [7:0]  acc_reg;
    logic [7:0]  acc_next;
    logic [7:0]  membrane_reg [NEURON_COUNT];

    logic        out_valid_reg;
    logic [7:0]  spikes_reg;

    logic [7:0]  membrane_out;
    logic        fire;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign spikes    = spikes_reg;

    snat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    snat_unit u_unit (
        .membrane        (membrane_reg[ctrl.idx]),
        .skip            (prev_spikes_reg[ctrl.idx]),
        .sensors         (sensors_reg),
        .icon            (sensor_conn_reg[8*ctrl.idx +: 8]),
        .ncon            (neuron_conn_reg[8*ctrl.idx +: 8]),
        .previous_spikes (prev_spikes_reg),
        .neuron_sign     (neuron_sign_reg),
        .base_threshold  (base_threshold_reg),
        .code            (jitter_reg[CODE_W*ctrl.idx +: CODE_W]),
        .membrane_out    (membrane_out),
        .fire            (fire)
    );

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.step)
        begin
            acc_next[ctrl.idx] = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_threshold_reg <= '0;
            neuron_sign_reg    <= '0;
            sensor_conn_reg    <= '0;
            neuron_conn_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_THRESHOLD:     base_threshold_reg <= cfg_data[7:0];
                REG_NEURON_SIGN:        neuron_sign_reg    <= cfg_data[7:0];
                REG_SENSOR_CONNECTIONS: sensor_conn_reg    <= cfg_data;
                REG_NEURON_CONNECTIONS: neuron_conn_reg    <= cfg_data;
                default:                base_threshold_reg <= base_threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_spikes_reg <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            for (int j = 0; j < NEURON_COUNT; j++)
            begin
                membrane_reg[j] <= '0;
            end
        end
        else
        begin
            if (ctrl.step)
            begin
                membrane_reg[ctrl.idx] <= membrane_out;
            end
            acc_reg <= acc_next;
            if (ctrl.finish)
            begin
                prev_spikes_reg <= acc_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sensors_reg <= sensor_spikes;
            jitter_reg  <= threshold_jitter;
        end
        if (ctrl.finish)
        begin
            spikes_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire
